### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the row box filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define RBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define RBF_ASSERT_NEVER(lbl, cond, msg) \
  `RBF_ASSERT(lbl, !(cond), msg)

`endif

### rtl/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// Types and fixed constants of the row box filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  localparam int COMP_W      = 16;
  localparam int SUM_W       = 22;
  localparam int LEN_W       = 6;
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RES_LIMIT   = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LEN_W-1:0]   WINDOW_LEN_RST   = 6'd31;
  localparam logic [RECIP_W-1:0] WINDOW_RECIP_RST = 17'd2114;

  // Register select, taken from paddr[2]
  localparam logic REG_WINDOW_LEN   = 1'b0;
  localparam logic REG_WINDOW_RECIP = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] blue_in;
    logic              row_end;
  } in_req_t;

  typedef struct packed {
    logic [COMP_W-1:0] red_out;
    logic [COMP_W-1:0] green_out;
    logic [COMP_W-1:0] blue_out;
    logic              row_done;
  } out_req_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pix_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    pix_t pix;
    logic first;
    logic last;
  } qitem_t;

endpackage

`default_nettype wire

### rtl/rbf_front.sv
// ----------------------------------------------------------------------------
// rbf_front
// Accepts pixels and marks first and last pixel of each row.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_front import rbf_pkg::*; #(
  parameter int ROW_MAX = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire in_req_t in_req,
  input  wire logic    q_full,
  output logic         q_push,
  output qitem_t       q_item
);

  localparam int POSW = (ROW_MAX > 2) ? $clog2(ROW_MAX) : 1;

  logic [POSW-1:0] pos_r, pos_nxt;
  logic            last;

  // Force a row end at the last position a row may have
  assign last   = in_req.row_end || (pos_r == POSW'(ROW_MAX - 1));
  assign q_push = in_valid && !q_full;

  assign q_item.pix.red   = in_req.red_in;
  assign q_item.pix.green = in_req.green_in;
  assign q_item.pix.blue  = in_req.blue_in;
  assign q_item.first     = (pos_r == '0);
  assign q_item.last      = last;

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = last ? '0 : pos_r + POSW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/rbf_queue.sv
// ----------------------------------------------------------------------------
// rbf_queue
// Short FIFO between front and back of the row box filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbf_queue import rbf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire qitem_t push_item,
  input  wire logic   pop,
  output logic        full,
  output logic        head_valid,
  output qitem_t      head_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qitem_t        slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `RBF_ASSERT(a_q_count_bound, cnt_r <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `RBF_ASSERT_NEVER(a_q_pop_empty, pop && (cnt_r == '0), "pop from empty queue")

endmodule

`default_nettype wire

### rtl/rbf_back.sv
// ----------------------------------------------------------------------------
// rbf_back
// Step sequencer, history ring, running sums, scaling and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbf_back import rbf_pkg::*; #(
  parameter int WINDOW_MAX    = 63,
  parameter int HISTORY_DEPTH = 64,
  parameter int ROW_MAX       = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [LEN_W-1:0]   window_len,
  input  wire logic [RECIP_W-1:0] window_reciprocal,
  input  wire logic               q_valid,
  input  wire qitem_t             q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  output out_req_t                out_req,
  input  wire logic               out_stall
);

  localparam int HALF_A   = (WINDOW_MAX - 1) / 2;
  localparam int HALF_B   = (HISTORY_DEPTH - 2) / 2;
  localparam int HALF_AB  = (HALF_A < HALF_B) ? HALF_A : HALF_B;
  localparam int HALF_MAX = (HALF_AB < RES_LIMIT - 1) ? HALF_AB : RES_LIMIT - 1;
  localparam int HW       = $clog2(HALF_MAX + 1);
  localparam int NW       = HW + 1;
  localparam int IDXW_A   = $clog2(ROW_MAX + HALF_MAX);
  localparam int IDXW     = (IDXW_A > NW) ? IDXW_A : NW;
  localparam int PW       = $clog2(HISTORY_DEPTH);
  localparam int MW       = COMP_W + HW + 1;
  localparam int RND_W    = PROD_W + 1;
  localparam int QW       = RND_W - COMP_W;

  localparam logic [PW:0]      DEPTH_C = (PW + 1)'(HISTORY_DEPTH);
  localparam logic [RND_W-1:0] ROUND_C = RND_W'(32768);
  localparam logic [QW-1:0]    SAT_C   = QW'(65535);

  // --------------------------------------------------------------------------
  // Half width from the length register
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] half_raw;
  logic [HW-1:0]    eff_half;

  always_comb begin
    len_eff  = (window_len == '0) ? LEN_W'(1) : window_len;
    half_raw = (len_eff - LEN_W'(1)) >> 1;
    eff_half = (half_raw > LEN_W'(HALF_MAX)) ? HW'(HALF_MAX) : half_raw[HW-1:0];
  end

  // --------------------------------------------------------------------------
  // Step sequencer
  // --------------------------------------------------------------------------
  logic            adv;
  logic            flushing;
  logic            issue;
  logic            is_pix;
  logic            row_start;
  logic [HW-1:0]   h_use;
  logic [NW-1:0]   n_use;
  logic [IDXW-1:0] idx;
  logic [PW-1:0]   ptr, ptr_inc, old_ptr;
  logic [PW:0]     ptr_ext, n_ext;
  pix_t            x;
  logic            step_done;

  logic [HW-1:0]   h_r, h_nxt;
  logic [HW-1:0]   flush_left_r, flush_left_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [PW-1:0]   ptr_r, ptr_nxt;
  pix_t            last_pix_r;
  pix_t            first_pix_r;

  assign adv       = !out_valid || !out_stall;
  assign flushing  = (flush_left_r != '0);
  assign is_pix    = !flushing && q_valid;
  assign issue     = flushing || q_valid;
  assign q_pop     = adv && is_pix;
  assign row_start = is_pix && q_item.first;

  always_comb begin
    h_use     = row_start ? eff_half : h_r;
    n_use     = {h_use, 1'b1};
    idx       = row_start ? '0 : idx_r;
    ptr       = row_start ? '0 : ptr_r;
    x         = flushing ? last_pix_r : q_item.pix;
    ptr_inc   = (ptr == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr + PW'(1);
    ptr_ext   = {1'b0, ptr};
    n_ext     = (PW + 1)'(n_use);
    old_ptr   = (ptr_ext >= n_ext) ? PW'(ptr_ext - n_ext) : PW'(ptr_ext + DEPTH_C - n_ext);
    step_done = flushing ? (flush_left_r == HW'(1)) : (q_item.last && (h_use == '0));

    h_nxt          = h_r;
    flush_left_nxt = flush_left_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    if (adv && issue) begin
      h_nxt   = h_use;
      idx_nxt = idx + IDXW'(1);
      ptr_nxt = ptr_inc;
      if (flushing) begin
        flush_left_nxt = flush_left_r - HW'(1);
      end else if (q_item.last) begin
        flush_left_nxt = h_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r          <= '0;
      flush_left_r <= '0;
      idx_r        <= '0;
      ptr_r        <= '0;
    end else begin
      h_r          <= h_nxt;
      flush_left_r <= flush_left_nxt;
      idx_r        <= idx_nxt;
      ptr_r        <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      last_pix_r <= q_item.pix;
    end
    if (adv && row_start) begin
      first_pix_r <= q_item.pix;
    end
  end

  // --------------------------------------------------------------------------
  // History ring: write the new pixel, read the sample leaving the window
  // --------------------------------------------------------------------------
  pix_t hist_mem [HISTORY_DEPTH];
  pix_t hist_rd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (is_pix) begin
        hist_mem[ptr] <= q_item.pix;
      end
      hist_rd_r <= hist_mem[old_ptr];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers: classified step
  // --------------------------------------------------------------------------
  logic          s1_valid_r;
  pix_t          s1_x_r;
  logic [HW-1:0] s1_h_r;
  logic          s1_first_r;
  logic          s1_add_only_r;
  logic          s1_use_hist_r;
  logic          s1_emit_r;
  logic          s1_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r        <= x;
      s1_h_r        <= h_use;
      s1_first_r    <= (idx == '0);
      s1_add_only_r <= (idx <= IDXW'(h_use));
      s1_use_hist_r <= (idx > IDXW'(n_use));
      s1_emit_r     <= (idx >= IDXW'(h_use));
      s1_done_r     <= step_done;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: running sums
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  sum_r   [3];
  logic [SUM_W-1:0]  sum_nxt [3];
  logic [SUM_W-1:0]  s2_sum_r [3];
  logic [COMP_W-1:0] xin     [3];
  logic [COMP_W-1:0] oin     [3];
  logic [MW-1:0]     seed    [3];
  pix_t              old_pix;
  logic              s2_valid_r;
  logic              s2_done_r;

  always_comb begin
    old_pix = s1_use_hist_r ? hist_rd_r : first_pix_r;
    xin[0]  = s1_x_r.red;
    xin[1]  = s1_x_r.green;
    xin[2]  = s1_x_r.blue;
    oin[0]  = old_pix.red;
    oin[1]  = old_pix.green;
    oin[2]  = old_pix.blue;
    for (int c = 0; c < 3; c++) begin
      seed[c] = MW'(xin[c]) * (MW'(s1_h_r) + MW'(1));
      if (s1_first_r) begin
        sum_nxt[c] = SUM_W'(seed[c]);
      end else if (s1_add_only_r) begin
        sum_nxt[c] = sum_r[c] + SUM_W'(xin[c]);
      end else begin
        sum_nxt[c] = sum_r[c] + SUM_W'(xin[c]) - SUM_W'(oin[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= '0;
      end
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      if (s1_valid_r) begin
        for (int c = 0; c < 3; c++) begin
          sum_r[c] <= sum_nxt[c];
        end
      end
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s2_sum_r[c] <= sum_nxt[c];
      end
      s2_done_r <= s1_done_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale by the reciprocal
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] s3_prod_r [3];
  logic              s3_valid_r;
  logic              s3_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s3_prod_r[c] <= PROD_W'(s2_sum_r[c]) * PROD_W'(window_reciprocal);
      end
      s3_done_r <= s2_done_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round, saturate, result register
  // --------------------------------------------------------------------------
  logic [RND_W-1:0]  rnd [3];
  logic [QW-1:0]     quo [3];
  logic [COMP_W-1:0] sat [3];
  logic              out_valid_r;
  out_req_t          out_req_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = RND_W'(s3_prod_r[c]) + ROUND_C;
      quo[c] = rnd[c][RND_W-1:COMP_W];
      sat[c] = (quo[c] > SAT_C) ? COMP_W'(65535) : quo[c][COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_req_r.red_out   <= sat[0];
      out_req_r.green_out <= sat[1];
      out_req_r.blue_out  <= sat[2];
      out_req_r.row_done  <= s3_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  `RBF_ASSERT(a_flush_bound, flush_left_r <= h_r, "flush run longer than half width")
  `RBF_ASSERT(a_done_emits, (s1_valid_r && s1_done_r) |-> s1_emit_r,
              "row end step without a result")
  `RBF_ASSERT_NEVER(a_pop_in_flush, q_pop && flushing, "pixel taken during flush run")

endmodule

`default_nettype wire

### rtl/row_box_filter_clamped.sv
// ----------------------------------------------------------------------------
// row_box_filter_clamped
// Horizontal box filter over RGB rows with edge clamping and scaled output.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | in_req_t  (RGB + row_end)
//  out_    | output    | out_valid / out_stall  | out_req_t (RGB + row_done)
//  cfg_    | input     | APB, pready always 1   | window_len @0, reciprocal @4
//
//  One pixel per cycle is taken while the back end keeps up; each pixel is
//  one step of the running-sum unit. At a row end the unit runs p flush
//  steps (p = half width); the 4-entry request queue holds up to four
//  pixels arriving meanwhile. A result passes the stage 1, running-sum,
//  product and result registers after its step issues.
//  Reset (rst_n low, synchronous) empties the queue and the pipeline and
//  loads window_len = 31 and window_reciprocal = 2114.
//  An output stall freezes the whole back end while out_valid is high;
//  input stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module row_box_filter_clamped import rbf_pkg::*; #(
  parameter int WINDOW_MAX    = 63,
  parameter int HISTORY_DEPTH = 64,
  parameter int ROW_MAX       = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel requests
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_req_t               in_req,
  // filtered pixel requests
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_req_t                   out_req,
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]   window_len_r, window_len_nxt;
  logic [RECIP_W-1:0] window_recip_r, window_recip_nxt;
  logic               cfg_wr;
  logic               cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  always_comb begin
    window_len_nxt   = window_len_r;
    window_recip_nxt = window_recip_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_WINDOW_LEN:   window_len_nxt   = cfg_pwdata[LEN_W-1:0];
        REG_WINDOW_RECIP: window_recip_nxt = cfg_pwdata[RECIP_W-1:0];
        default:          window_len_nxt   = window_len_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WINDOW_LEN:   cfg_prdata = CFG_DATA_W'(window_len_r);
      REG_WINDOW_RECIP: cfg_prdata = CFG_DATA_W'(window_recip_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r   <= WINDOW_LEN_RST;
      window_recip_r <= WINDOW_RECIP_RST;
    end else begin
      window_len_r   <= window_len_nxt;
      window_recip_r <= window_recip_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Front: take pixels, mark row start and row end
  // --------------------------------------------------------------------------
  logic   q_push;
  logic   q_full;
  qitem_t q_item_in;
  logic   q_pop;
  logic   q_valid;
  qitem_t q_head;

  assign in_stall = q_full;

  rbf_front #(
    .ROW_MAX (ROW_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_req),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item_in)
  );

  // Hold classified pixels while the back end flushes or stalls
  rbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  // --------------------------------------------------------------------------
  // Back: sequence steps, advance sums, scale and present results
  // --------------------------------------------------------------------------
  rbf_back #(
    .WINDOW_MAX    (WINDOW_MAX),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ROW_MAX       (ROW_MAX)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .window_len        (window_len_r),
    .window_reciprocal (window_recip_r),
    .q_valid           (q_valid),
    .q_item            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_req           (out_req),
    .out_stall         (out_stall)
  );

endmodule

`default_nettype wire

### sim/rbf_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Row box filter scoreboard
// Running-sum prediction of the filtered pixel stream and in-order checking.
// ----------------------------------------------------------------------------
package rbf_scoreboard_pkg;
  import rbf_pkg::*;

  localparam int HIST_DEPTH = 64;
  localparam int ROW_LIMIT  = 4096;

  class filter_scoreboard;
    logic [LEN_W-1:0]   window_len;
    logic [RECIP_W-1:0] window_recip;
    logic [COMP_W-1:0]  hist [HIST_DEPTH][3];
    logic [SUM_W-1:0]   sums [3];
    logic [COMP_W-1:0]  first_pix [3];
    int unsigned        in_pos;
    int unsigned        half;
    out_req_t           expected_q[$];
    int                 errors;
    int                 pixels;
    int                 rows;
    int                 results;

    function new();
      window_len   = WINDOW_LEN_RST;
      window_recip = WINDOW_RECIP_RST;
      foreach (hist[i, c]) hist[i][c] = '0;
      foreach (sums[c]) begin
        sums[c]      = '0;
        first_pix[c] = '0;
      end
      in_pos  = 0;
      half    = 0;
      errors  = 0;
      pixels  = 0;
      rows    = 0;
      results = 0;
    endfunction

    function void write_reg(logic sel, logic [CFG_DATA_W-1:0] data);
      if (sel == REG_WINDOW_LEN) window_len = data[LEN_W-1:0];
      else window_recip = data[RECIP_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Scale a window sum, round to nearest, clip to 16 bits.
    function logic [COMP_W-1:0] scale(logic [SUM_W-1:0] s);
      logic [63:0] v;
      v = (64'(s) * 64'(window_recip) + 64'd32768) >> 16;
      return (v > 64'd65535) ? 16'hFFFF : v[COMP_W-1:0];
    endfunction

    // Advance the sums by sample index i (value x), emit once the window is full.
    function void slide(int unsigned i, logic [COMP_W-1:0] x [3]);
      int unsigned       width;
      logic [COMP_W-1:0] old;
      out_req_t          r;
      width = 2 * half + 1;
      for (int c = 0; c < 3; c++) begin
        old = (i > width) ? hist[(i - width) % HIST_DEPTH][c] : first_pix[c];
        if (i == 0) sums[c] = SUM_W'((half + 1) * x[c]);
        else if (i <= half) sums[c] = sums[c] + x[c];
        else sums[c] = sums[c] + x[c] - old;
      end
      if (i >= half) begin
        r.red_out   = scale(sums[0]);
        r.green_out = scale(sums[1]);
        r.blue_out  = scale(sums[2]);
        r.row_done  = 1'b0;
        expected_q.push_back(r);
      end
    endfunction

    function void note_pixel(in_req_t px);
      logic [COMP_W-1:0] x [3];
      int unsigned       i;
      int unsigned       start;
      bit                last;
      out_req_t          r;
      x[0]  = px.red_in;
      x[1]  = px.green_in;
      x[2]  = px.blue_in;
      i     = in_pos;
      last  = px.row_end || (i >= ROW_LIMIT - 1);
      start = expected_q.size();
      if (i == 0) begin
        half      = (window_len == 0) ? 0 : (window_len - 1) / 2;
        first_pix = x;
      end
      hist[i % HIST_DEPTH] = x;
      slide(i, x);
      if (last) begin
        for (int unsigned k = 1; k <= half; k++) slide(i + k, x);
        if (expected_q.size() > start) begin
          r = expected_q.pop_back();
          r.row_done = 1'b1;
          expected_q.push_back(r);
        end
        in_pos = 0;
        rows++;
      end else begin
        in_pos = i + 1;
      end
      pixels++;
    endfunction

    function void compare(string name, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("red_out", want.red_out, got.red_out);
      compare("green_out", want.green_out, got.green_out);
      compare("blue_out", want.blue_out, got.blue_out);
      compare("row_done", COMP_W'(want.row_done), COMP_W'(got.row_done));
    endfunction
  endclass

endpackage

### sim/tb_row_box_filter_clamped.sv
// ----------------------------------------------------------------------------
// tb_row_box_filter_clamped
// Streams RGB rows through the box filter under random idling and stalls,
// reprograms window length and reciprocal between phases, and checks every
// filtered pixel in order against a running-sum predictor.
// ----------------------------------------------------------------------------
module tb_row_box_filter_clamped;
  import rbf_pkg::*;
  import rbf_scoreboard_pkg::*;

  localparam int    CLK_HALF     = 6;
  localparam int    RESET_CYCLES = 10;
  localparam int    IDLE_PCT     = 33;
  localparam int    DRAIN_CYCLES = 48;     // queue, flush of up to 31 steps, pipe
  localparam int    HOLD_CYCLES  = 300;
  localparam int    PHASES       = 8;
  localparam int    PHASE_ITEMS  = 48;
  localparam longint LIMIT_TIME  = 64'd7_200_000;
  localparam logic [COMP_W-1:0] COMP_MAX = '1;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_req_t               in_req      = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_req_t              out_req;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Idle rates of both sides, changed per phase by the stimulus process.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  // Flip to start a long receiver hold-off; the receiver counts it down itself.
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;
  int   cfg_writes  = 0;

  filter_scoreboard sb = new();

  always #CLK_HALF clk = ~clk;

  row_box_filter_clamped u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_req     (out_req),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Receiver: check each accepted request, then pick the stall for the next
  // cycle. A pending hold-off wins over the random idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_req);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if the stream never drains.
  initial begin
    #(LIMIT_TIME);
    $display("row_box_filter_clamped verification failed");
    $finish;
  end

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that closes the access phase (pready is tied high).
  task automatic apb_write(input logic sel, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(sel, data);
    cfg_writes++;
  endtask

  task automatic set_window(input int len, input int recip);
    apb_write(REG_WINDOW_LEN, CFG_DATA_W'(len));
    apb_write(REG_WINDOW_RECIP, CFG_DATA_W'(recip));
  endtask

  function automatic int recip_for(input int len);
    int n;
    n = (len == 0) ? 1 : len;
    return (65536 + n / 2) / n;
  endfunction

  function automatic in_req_t pixel_req(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                                        input logic [COMP_W-1:0] b, input logic last);
    in_req_t px;
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    px.row_end  = last;
    return px;
  endfunction

  // Lean on the rails now and then so clipping and dark rows both show up.
  function automatic logic [COMP_W-1:0] rand_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return COMP_MAX;
      default: return COMP_W'($urandom_range(65535));
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_pixel(input in_req_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic send_row(input int len, input bit close);
    for (int p = 0; p < len; p++)
      send_pixel(pixel_req(rand_channel(), rand_channel(), rand_channel(),
                           close && (p == len - 1)));
  endtask

  // Stop offering, drain every expected request, then let requests that
  // produce nothing yet leave the pipe before touching the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int len;
    int recip;
    int sent;
    int row_len;
    bit close;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (n = 31): single-pixel row at full scale, then a row
    // shorter than the half width, so the right side repeats the last pixel.
    send_pixel(pixel_req(COMP_MAX, COMP_MAX, COMP_MAX, 1'b1));
    send_pixel(pixel_req('0, '0, '0, 1'b0));
    send_pixel(pixel_req(COMP_MAX, '0, COMP_MAX, 1'b0));
    send_pixel(pixel_req('0, COMP_MAX, '0, 1'b1));
    wait_idle();

    // Zero length acts as one; unity scale passes samples through.
    set_window(0, 65536);
    send_pixel(pixel_req(COMP_MAX, 16'h0001, 16'h8000, 1'b0));
    send_pixel(pixel_req(16'h7FFF, COMP_MAX, '0, 1'b1));
    wait_idle();

    // Even length: window is still 2p+1 wide, scaled by the register as set.
    set_window(2, 32768);
    send_row(2, 1'b1);
    wait_idle();

    // Oversized scale on a bright row: drive the output into saturation.
    set_window(3, 65536);
    send_pixel(pixel_req(COMP_MAX, COMP_MAX, COMP_MAX, 1'b0));
    send_pixel(pixel_req(COMP_MAX, COMP_MAX, COMP_MAX, 1'b0));
    send_pixel(pixel_req(COMP_MAX, 16'hFFFE, 16'h8000, 1'b1));
    wait_idle();

    // Zero scale, then the widest window on a two-pixel row.
    set_window(7, 0);
    send_row(2, 1'b1);
    wait_idle();
    set_window(63, 1040);
    send_row(2, 1'b1);
    wait_idle();

    // Length change in mid-row: the running row keeps its half width.
    set_window(5, 13107);
    send_row(3, 1'b0);
    wait_idle();
    set_window(9, 7282);
    send_row(3, 1'b1);
    wait_idle();

    // Long row on the widest window so the history ring wraps, then a
    // short row follows under the same settings.
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    set_window(63, 1040);
    send_row(90, 1'b1);
    send_row(5, 1'b1);
    wait_idle();

    // Random phases: new settings each phase; odd phases but the last leave the
    // last row open so the next write lands in mid-row.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: len = 63;
        1: len = 1;
        3: len = 0;
        5: len = 2 * $urandom_range(1, 31);
        default: len = $urandom_range(1, 63);
      endcase
      recip = (ph == 4) ? $urandom_range(0, 65536) : recip_for(len);
      set_window(len, recip);

      // First phase runs flat out on both sides.
      tx_idle_pct = (ph == 0) ? 0 : IDLE_PCT;
      rx_idle_pct = (ph == 0) ? 0 : IDLE_PCT;

      // Hold the receiver while requests keep coming, to back up the queue.
      if (ph == 2) hold_toggle <= ~hold_toggle;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        row_len = ($urandom_range(9) == 0) ? $urandom_range(41, 130) : $urandom_range(1, 40);
        close   = 1'b1;
        if (sent + row_len >= PHASE_ITEMS) begin
          row_len = PHASE_ITEMS - sent;
          close   = (ph % 2 == 0) || (ph == PHASES - 1);
        end
        send_row(row_len, close);
        sent += row_len;
      end
      wait_idle();
    end

    $display("Covered %0d pixels in %0d rows, %0d filtered pixels checked",
             sb.pixels, sb.rows, sb.results);
    $display("%0d register writes, a ring-wrapping long row and %0d random setting phases",
             cfg_writes, PHASES);
    if (sb.errors == 0) begin
      $display("row_box_filter_clamped verification clean");
    end else begin
      $display("row_box_filter_clamped verification failed");
    end
    $finish;
  end

endmodule
